### rtl/core/sfd_pkg.sv
// Shared types, result codes and the CRC-16 byte update for the frame deframer.
// No dependencies; every other file in rtl/core imports this package.
package sfd_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN     = 2'd2;

  localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
  localparam logic [1:0] KIND_ACCEPT     = 2'd1;
  localparam logic [1:0] KIND_CRC_ERR    = 2'd2;
  localparam logic [1:0] KIND_MARKER_ERR = 2'd3;

  localparam logic [3:0] HdrLastIdx = 4'd8;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CRC     = 5'b01000,
    PH_END     = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
    logic [15:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [7:0]  frame_kind;
    logic [15:0] sequence_res;
    logic [31:0] time_stamp;
    logic [15:0] payload_length;
  } res_t;

  // CRC-16 with polynomial 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### rtl/core/sfd_cfg_regs.sv
// Configuration registers of the deframer: sync bytes and payload length limit.
// Depends on sfd_pkg for the register indexes, the cfg_t bundle and crc_byte.
module sfd_cfg_regs import sfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [15:0]        wr_data_i,
  output cfg_t               cfg_o
);

  logic [7:0]  sync_first_q;
  logic [7:0]  sync_second_q;
  logic [15:0] max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'hAA;
      sync_second_q <= 8'h55;
      max_len_q     <= 16'hFFFF;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_SYNC_FIRST:  sync_first_q  <= wr_data_i[7:0];
        CFG_SYNC_SECOND: sync_second_q <= wr_data_i[7:0];
        CFG_MAX_LEN:     max_len_q     <= wr_data_i;
        default: ;
      endcase
    end
  end

  // The CRC restarts over both sync bytes once the second one is seen.
  assign cfg_o.sync_first  = sync_first_q;
  assign cfg_o.sync_second = sync_second_q;
  assign cfg_o.max_len     = max_len_q;
  assign cfg_o.crc_seed    = crc_byte(crc_byte(CrcInit, sync_first_q), sync_second_q);

endmodule

### rtl/core/sfd_parser.sv
// Frame parser: hunt, header capture, payload pass-through, CRC and end marker check.
// Depends on sfd_pkg; advances by one byte for each step and reports at most one result.
module sfd_parser import sfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic        seen_q, seen_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] stamp_q, stamp_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pcnt_q, pcnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held_q, held_d;

  logic [15:0] crc_upd;
  logic [15:0] len_new;
  logic [16:0] pcnt_inc;

  assign crc_upd  = crc_byte(crc_q, byte_i);
  assign len_new  = {len_q[7:0], byte_i};
  assign pcnt_inc = {1'b0, pcnt_q} + 17'd1;

  always_comb begin
    phase_d = phase_q;
    seen_d  = seen_q;
    fcnt_d  = fcnt_q;
    type_d  = type_q;
    seq_d   = seq_q;
    stamp_d = stamp_q;
    len_d   = len_q;
    pcnt_d  = pcnt_q;
    crc_d   = crc_q;
    held_d  = held_q;

    res_valid_o          = 1'b0;
    res_o.kind           = KIND_PAYLOAD;
    res_o.data_byte      = 8'h00;
    res_o.byte_offset    = 16'h0000;
    res_o.frame_kind     = type_q;
    res_o.sequence_res   = seq_q;
    res_o.time_stamp     = stamp_q;
    res_o.payload_length = len_q;

    case (phase_q)
      PH_HEADER: begin
        crc_d  = crc_upd;
        fcnt_d = fcnt_q + 4'd1;
        if (fcnt_q == 4'd0) begin
          type_d = byte_i;
        end else if (fcnt_q <= 4'd2) begin
          seq_d = {seq_q[7:0], byte_i};
        end else if (fcnt_q <= 4'd6) begin
          stamp_d = {stamp_q[23:0], byte_i};
        end else begin
          len_d = len_new;
        end
        // Only the last header byte can be the low length byte.
        if (fcnt_q >= HdrLastIdx) begin
          fcnt_d = 4'd0;
          if (len_new == 16'h0000 || len_new > cfg_i.max_len) begin
            phase_d = PH_HUNT;
            seen_d  = 1'b0;
          end else begin
            pcnt_d  = 16'h0000;
            phase_d = PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        crc_d             = crc_upd;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_PAYLOAD;
        res_o.data_byte   = byte_i;
        res_o.byte_offset = pcnt_q;
        pcnt_d            = pcnt_inc[15:0];
        if (pcnt_inc >= {1'b0, len_q}) begin
          phase_d = PH_CRC;
          fcnt_d  = 4'd0;
        end
      end

      PH_CRC: begin
        if (fcnt_q == 4'd0) begin
          held_d = byte_i;
          fcnt_d = 4'd1;
        end else begin
          fcnt_d = 4'd0;
          if ({held_q, byte_i} == crc_q) begin
            phase_d = PH_END;
          end else begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_CRC_ERR;
            phase_d     = PH_HUNT;
            seen_d      = 1'b0;
          end
        end
      end

      PH_END: begin
        if (fcnt_q == 4'd0) begin
          held_d = byte_i;
          fcnt_d = 4'd1;
        end else begin
          res_valid_o = 1'b1;
          if (held_q == cfg_i.sync_second && byte_i == cfg_i.sync_first) begin
            res_o.kind = KIND_ACCEPT;
          end else begin
            res_o.kind = KIND_MARKER_ERR;
          end
          phase_d = PH_HUNT;
          seen_d  = 1'b0;
          fcnt_d  = 4'd0;
        end
      end

      default: begin
        // Hunt. A broken sync pair does not re-arm on the byte that broke it.
        phase_d = PH_HUNT;
        if (!seen_q && byte_i == cfg_i.sync_first) begin
          seen_d = 1'b1;
        end else if (seen_q && byte_i == cfg_i.sync_second) begin
          seen_d  = 1'b0;
          fcnt_d  = 4'd0;
          crc_d   = cfg_i.crc_seed;
          phase_d = PH_HEADER;
        end else begin
          seen_d = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      seen_q  <= 1'b0;
      fcnt_q  <= 4'd0;
      type_q  <= 8'h00;
      seq_q   <= 16'h0000;
      stamp_q <= 32'h0000_0000;
      len_q   <= 16'h0000;
      pcnt_q  <= 16'h0000;
      crc_q   <= CrcInit;
      held_q  <= 8'h00;
    end else if (step_i) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      fcnt_q  <= fcnt_d;
      type_q  <= type_d;
      seq_q   <= seq_d;
      stamp_q <= stamp_d;
      len_q   <= len_d;
      pcnt_q  <= pcnt_d;
      crc_q   <= crc_d;
      held_q  <= held_d;
    end
  end

endmodule

### rtl/core/sync_frame_deframer_crc16.sv
// Sync-framed packet deframer with CRC-16 check: one received byte per input beat.
// A byte is held in the input register and its result, if any, in the result register.
// Throughput: one byte per cycle while out_ready_i is high; the input register and
// the result register each take a new beat in the same cycle as the old one leaves.
// Reset: rst_ni is asynchronous and active low; it empties both registers and
// returns the parser to the sync hunt with the default configuration.
module sync_frame_deframer_crc16 import sfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic [15:0]        byte_offset_o,
  output logic [7:0]         frame_kind_o,
  output logic [15:0]        sequence_res_o,
  output logic [31:0]        time_stamp_o,
  output logic [15:0]        payload_length_o
);

  cfg_t        cfg;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        step;
  logic        res_valid;
  res_t        res;
  logic        out_vld_q;
  res_t        out_q;

  assign cfg_ready_o = 1'b1;

  sfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The held byte is processed once the result register is free or draining.
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= res_valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign kind_o           = out_q.kind;
  assign data_byte_o      = out_q.data_byte;
  assign byte_offset_o    = out_q.byte_offset;
  assign frame_kind_o     = out_q.frame_kind;
  assign sequence_res_o   = out_q.sequence_res;
  assign time_stamp_o     = out_q.time_stamp;
  assign payload_length_o = out_q.payload_length;

endmodule
